/* rtl/pslf_pkg.sv */
// pslf_pkg: shared types and constants of the pam-3 sample level front end
// transaction structs, register indexes, reset values, level codes, fsm states
// no dependencies
package pslf_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DC_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LVL_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LVL_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_ZERO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_ZERO  = 3'd6;

  // register reset values
  localparam logic                RST_DC_ENABLE = 1'b1;
  localparam logic [SAMPLE_W-1:0] RST_DC_HIGH   = 8'd180;
  localparam logic [SAMPLE_W-1:0] RST_DC_LOW    = 8'd70;
  localparam logic [SAMPLE_W-1:0] RST_LVL_HIGH  = 8'd140;
  localparam logic [SAMPLE_W-1:0] RST_LVL_LOW   = 8'd95;
  localparam logic [SAMPLE_W-1:0] RST_RISE_ZERO = 8'd80;
  localparam logic [SAMPLE_W-1:0] RST_FALL_ZERO = 8'd160;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 8'd0;

  // pam-3 level codes, two's complement
  localparam logic signed [1:0] LVL_NEG  = 2'sb11;
  localparam logic signed [1:0] LVL_ZERO = 2'sb00;
  localparam logic signed [1:0] LVL_POS  = 2'sb01;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                block_first;
    logic                block_last;
  } pslf_in_t;

  typedef struct packed {
    logic signed [1:0]   level;
    logic [SAMPLE_W-1:0] corrected_sample;
    logic                spike_removed;
    logic                result_last;
  } pslf_out_t;

  typedef struct packed {
    logic                dc_enable;
    logic [SAMPLE_W-1:0] dc_high_limit;
    logic [SAMPLE_W-1:0] dc_low_limit;
    logic [SAMPLE_W-1:0] level_high_threshold;
    logic [SAMPLE_W-1:0] level_low_threshold;
    logic [SAMPLE_W-1:0] rise_zero_threshold;
    logic [SAMPLE_W-1:0] fall_zero_threshold;
  } pslf_cfg_t;

  // results of one sample, handed from the level unit to the output queue
  typedef struct packed {
    logic      a_valid;
    pslf_out_t a;
    logic      b_valid;
    pslf_out_t b;
  } pslf_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC
  } pslf_state_e;

endpackage

/* rtl/pam3_sample_level_frontend.sv */
// pam3_sample_level_frontend: top level of the pam-3 sample level front end
// depends on pslf_pkg, pslf_cell and pslf_level
//
// One sample transaction is taken at a time. With dc correction on, the
// sample is shifted into a chain of WINDOW_LEN cells (newest in cell 0) and
// a running min and max walks down the chain one cell per clock. A sample
// passes through the accept step, the scan down all WINDOW_LEN cells and
// a step that classifies and queues the results. With correction off the
// scan is skipped. Each sample yields zero, one or two result transactions
// (the delayed result of the previous sample and, on the last sample of a
// block, its own result); they go into a two entry output queue, and the
// queueing step waits while the queue lacks room. Only cells below the
// fill count take part in the min and max, so the window needs no clearing
// after reset. Configuration writes are always taken and must only be
// issued while the block is idle.
module pam3_sample_level_frontend import pslf_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pslf_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pslf_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SAMPLE_W-1:0]  cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SCAN_W = $clog2(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WINDOW_LEN - 1);

  // configuration registers
  pslf_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dc_enable: RST_DC_ENABLE, dc_high_limit: RST_DC_HIGH,
                 dc_low_limit: RST_DC_LOW, level_high_threshold: RST_LVL_HIGH,
                 level_low_threshold: RST_LVL_LOW, rise_zero_threshold: RST_RISE_ZERO,
                 fall_zero_threshold: RST_FALL_ZERO};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DC_ENABLE: cfg_q.dc_enable            <= cfg_data_i[0];
        CFG_DC_HIGH:   cfg_q.dc_high_limit        <= cfg_data_i;
        CFG_DC_LOW:    cfg_q.dc_low_limit         <= cfg_data_i;
        CFG_LVL_HIGH:  cfg_q.level_high_threshold <= cfg_data_i;
        CFG_LVL_LOW:   cfg_q.level_low_threshold  <= cfg_data_i;
        CFG_RISE_ZERO: cfg_q.rise_zero_threshold  <= cfg_data_i;
        CFG_FALL_ZERO: cfg_q.fall_zero_threshold  <= cfg_data_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // control
  pslf_state_e       state_q, state_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [FILL_W-1:0] fill_q, fill_d, fill_base;
  pslf_in_t          item_q;
  logic              in_acc;
  logic              shift;
  logic              commit;
  pslf_res_t         res;
  logic [1:0]        need;

  // output queue
  pslf_out_t         ent_q [2];
  pslf_out_t         ent_d [2];
  logic [1:0]        cnt_q, cnt_d;
  logic              room;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign shift      = in_acc && cfg_q.dc_enable;

  assign need = {1'b0, res.a_valid} + {1'b0, res.b_valid};
  assign room = ({1'b0, cnt_q} + {1'b0, need}) <= 3'd2;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (in_acc) begin
          state_d = cfg_q.dc_enable ? ST_SCAN : ST_CALC;
        end
      end
      ST_SCAN: begin
        // min and max walk down the chain until they reach its end
        scan_d = scan_q + 1'b1;
        if (scan_q == SCAN_LAST) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (room) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // window fill count, restarted by the first sample of a block
  always_comb begin
    fill_base = in_data_i.block_first ? '0 : fill_q;
    fill_d    = fill_q;
    if (in_acc) begin
      fill_d = fill_base;
      if (cfg_q.dc_enable && (fill_base < FILL_FULL)) begin
        fill_d = fill_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  // window chain
  logic [SAMPLE_W-1:0] chain_sample [WINDOW_LEN+1];
  logic [SAMPLE_W-1:0] chain_min    [WINDOW_LEN+1];
  logic [SAMPLE_W-1:0] chain_max    [WINDOW_LEN+1];

  assign chain_sample[0] = in_data_i.sample;
  assign chain_min[0]    = SAMPLE_MAX;
  assign chain_max[0]    = SAMPLE_MIN;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    pslf_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .sample_i   (chain_sample[i]),
      .in_window_i(FILL_W'(i) < fill_q),
      .min_i      (chain_min[i]),
      .max_i      (chain_max[i]),
      .sample_o   (chain_sample[i+1]),
      .min_o      (chain_min[i+1]),
      .max_o      (chain_max[i+1])
    );
  end

  pslf_level u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .win_min_i(chain_min[WINDOW_LEN]),
    .win_max_i(chain_max[WINDOW_LEN]),
    .commit_i (commit),
    .res_o    (res)
  );

  // two entry output queue, head drives the port
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (out_valid_o && out_ready_i) begin
      ent_d[0] = ent_q[1];
      cnt_d    = cnt_q - 1'b1;
    end
    if (commit && res.a_valid) begin
      ent_d[cnt_d[0]] = res.a;
      cnt_d           = cnt_d + 1'b1;
    end
    if (commit && res.b_valid) begin
      ent_d[cnt_d[0]] = res.b;
      cnt_d           = cnt_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];

endmodule

/* rtl/pslf_cell.sv */
// pslf_cell: one window cell, holds a sample and forwards a running min and max
// depends on pslf_pkg
module pslf_cell import pslf_pkg::*; (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                in_window_i,
  input  logic [SAMPLE_W-1:0] min_i,
  input  logic [SAMPLE_W-1:0] max_i,
  output logic [SAMPLE_W-1:0] sample_o,
  output logic [SAMPLE_W-1:0] min_o,
  output logic [SAMPLE_W-1:0] max_o
);

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;

  always_comb begin
    min_d = min_i;
    max_d = max_i;
    if (in_window_i && (sample_q < min_i)) begin
      min_d = sample_q;
    end
    if (in_window_i && (sample_q > max_i)) begin
      max_d = sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
    min_q <= min_d;
    max_q <= max_d;
  end

  assign sample_o = sample_q;
  assign min_o    = min_q;
  assign max_o    = max_q;

endmodule

/* rtl/pslf_level.sv */
// pslf_level: dc correction, level classification, spike filter and held result
// depends on pslf_pkg
module pslf_level import pslf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pslf_cfg_t           cfg_i,
  input  pslf_in_t            item_i,
  input  logic [SAMPLE_W-1:0] win_min_i,
  input  logic [SAMPLE_W-1:0] win_max_i,
  input  logic                commit_i,
  output pslf_res_t           res_o
);

  logic [SAMPLE_W-1:0] prev_corr_q;
  logic signed [1:0]   prev_level_q;
  logic signed [1:0]   held_level_q;
  logic [SAMPLE_W-1:0] held_corr_q;
  logic signed [1:0]   emitted_q;
  logic                held_valid_q;
  logic                held_first_q;

  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W:0]   shifted;
  logic [SAMPLE_W-1:0] corr;
  logic signed [1:0]   base_level;
  logic signed [1:0]   lv;
  logic                spike;
  logic signed [1:0]   held_out;
  logic                first;

  assign first = item_i.block_first;

  always_comb begin
    sum     = {1'b0, item_i.sample} + {1'b0, cfg_i.level_low_threshold};
    shifted = (sum >= {1'b0, win_min_i}) ? (sum - {1'b0, win_min_i}) : '0;
    corr    = item_i.sample;
    if (cfg_i.dc_enable && (win_max_i > cfg_i.dc_high_limit)
        && (win_min_i < cfg_i.dc_low_limit) && (shifted < {1'b0, SAMPLE_MAX})) begin
      corr = shifted[SAMPLE_W-1:0];
    end
  end

  // slope dependent thresholds, the level is held when none applies
  always_comb begin
    base_level = first ? LVL_ZERO : prev_level_q;
    lv         = base_level;
    if (first || (corr == prev_corr_q)) begin
      if (corr >= cfg_i.level_high_threshold) begin
        lv = LVL_POS;
      end else if (corr <= cfg_i.level_low_threshold) begin
        lv = LVL_NEG;
      end
    end else if (corr > prev_corr_q) begin
      if (corr >= cfg_i.level_high_threshold) begin
        lv = LVL_POS;
      end else if (corr > cfg_i.rise_zero_threshold) begin
        lv = LVL_ZERO;
      end
    end else begin
      if (corr <= cfg_i.level_low_threshold) begin
        lv = LVL_NEG;
      end else if (corr < cfg_i.fall_zero_threshold) begin
        lv = LVL_ZERO;
      end
    end
  end

  // single sample spike between equal neighbours
  always_comb begin
    spike = !held_first_q && (held_level_q != emitted_q) && (held_level_q != lv)
            && (emitted_q == lv);
    held_out = spike ? emitted_q : held_level_q;
  end

  always_comb begin
    res_o.a_valid = held_valid_q;
    if (first) begin
      // new block flushes the held result unfiltered
      res_o.a = '{level: held_level_q, corrected_sample: held_corr_q,
                  spike_removed: 1'b0, result_last: 1'b0};
    end else begin
      res_o.a = '{level: held_out, corrected_sample: held_corr_q,
                  spike_removed: spike, result_last: 1'b0};
    end
    res_o.b_valid = item_i.block_last;
    res_o.b       = '{level: lv, corrected_sample: corr,
                      spike_removed: 1'b0, result_last: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_corr_q  <= '0;
      prev_level_q <= LVL_ZERO;
      held_level_q <= LVL_ZERO;
      held_corr_q  <= '0;
      emitted_q    <= LVL_ZERO;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
    end else if (commit_i) begin
      prev_corr_q  <= corr;
      prev_level_q <= lv;
      if (held_valid_q && !first) begin
        emitted_q <= held_out;
      end
      if (item_i.block_last) begin
        held_valid_q <= 1'b0;
      end else begin
        held_level_q <= lv;
        held_corr_q  <= corr;
        held_first_q <= first;
        held_valid_q <= 1'b1;
      end
    end
  end

endmodule

/* rtl/pslf_checker.sv */
// pslf_checker: port level assertions for the pam-3 sample level front end
// depends on pslf_pkg, bound to pam3_sample_level_frontend
module pslf_checker import pslf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pslf_out_t out_data_o
);

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a sample is still in work");

  // only filtered results can carry a removed spike
  a_spike_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.spike_removed) |-> !out_data_o.result_last)
    else $error("spike flag on a block's last result");

  a_level_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.level != 2'b10))
    else $error("level code outside minus one to plus one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result transaction changed");

endmodule

bind pam3_sample_level_frontend pslf_checker u_pslf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

/* tb/sv/tb_pam3_sample_level_frontend.sv */
// tb_pam3_sample_level_frontend: self-checking testbench of the pam-3 sample level front end
// a directed table, then random blocks under several register settings, checked by a predictor
// depends on pslf_pkg and pam3_sample_level_frontend
module tb_pam3_sample_level_frontend;
  import pslf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_LEN      = 128;
  // long enough to cover any sample still in flight
  localparam int unsigned SETTLE_CYCLES = 2 * WIN_LEN + 16;
  localparam int unsigned CYCLE_LIMIT  = 2500000;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam int unsigned HOLD_TRIGGER = 300;
  // the one register index the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

  // one row of the directed table; typed rows carry the result of the sample itself
  typedef struct {
    pslf_in_t  item;
    bit        typed;
    pslf_out_t result;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  pslf_in_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  pslf_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SAMPLE_W-1:0]  cfg_data_i = '0;

  pam3_sample_level_frontend #(.WINDOW_LEN(WIN_LEN)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: register shadow and a private copy of the block's state
  // ---------------------------------------------------------------------------
  pslf_cfg_t shadow_cfg = '{dc_enable: RST_DC_ENABLE, dc_high_limit: RST_DC_HIGH,
                            dc_low_limit: RST_DC_LOW, level_high_threshold: RST_LVL_HIGH,
                            level_low_threshold: RST_LVL_LOW,
                            rise_zero_threshold: RST_RISE_ZERO,
                            fall_zero_threshold: RST_FALL_ZERO};

  logic [SAMPLE_W-1:0] win_mem [WIN_LEN];
  int unsigned         win_pos = 0;
  int unsigned         win_fill = 0;
  int unsigned         last_corr = 0;
  logic signed [1:0]   last_lvl = LVL_ZERO;
  logic signed [1:0]   held_lvl = LVL_ZERO;
  int unsigned         held_corr = 0;
  logic signed [1:0]   sent_lvl = LVL_ZERO;
  bit                  held_valid = 1'b0;
  bit                  held_first = 1'b0;

  // levels still owed by the block, oldest first
  pslf_out_t pending_levels [$];

  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned settings_loaded = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  task automatic queue_level(input logic signed [1:0] lv, input int unsigned corr,
                             input bit spike, input bit last);
    pslf_out_t r;
    r.level            = lv;
    r.corrected_sample = corr[SAMPLE_W-1:0];
    r.spike_removed    = spike;
    r.result_last      = last;
    pending_levels.push_back(r);
  endtask

  // works out the levels that one accepted sample releases
  task automatic predict_levels(input pslf_in_t item);
    int unsigned       s;
    int unsigned       c;
    int unsigned       mn;
    int unsigned       mx;
    int unsigned       t;
    logic signed [1:0] lv;
    logic signed [1:0] o;
    bit                spike;
    s = item.sample;
    c = s;

    // a new block flushes whatever the old one left behind, unfiltered
    if (item.block_first && held_valid) begin
      queue_level(held_lvl, held_corr, 1'b0, 1'b0);
      held_valid = 1'b0;
    end
    if (item.block_first) begin
      win_pos  = 0;
      win_fill = 0;
      last_lvl = LVL_ZERO;
    end

    // window min/max and dc shift, only while correction is on
    if (shadow_cfg.dc_enable) begin
      mn = SAMPLE_MAX;
      mx = SAMPLE_MIN;
      win_mem[win_pos] = item.sample;
      win_pos = (win_pos + 1) % WIN_LEN;
      if (win_fill < WIN_LEN) win_fill++;
      for (int unsigned j = 0; j < win_fill; j++) begin
        if (win_mem[j] < mn) mn = win_mem[j];
        if (win_mem[j] > mx) mx = win_mem[j];
      end
      if (mx > shadow_cfg.dc_high_limit && mn < shadow_cfg.dc_low_limit) begin
        t = s + shadow_cfg.level_low_threshold;
        t = (t >= mn) ? t - mn : 0;
        if (t < SAMPLE_MAX) c = t;
      end
    end

    // slope-dependent slicing, the level is held when no threshold applies
    lv = last_lvl;
    if (item.block_first || c == last_corr) begin
      if (c >= shadow_cfg.level_high_threshold) lv = LVL_POS;
      else if (c <= shadow_cfg.level_low_threshold) lv = LVL_NEG;
    end else if (c > last_corr) begin
      if (c >= shadow_cfg.level_high_threshold) lv = LVL_POS;
      else if (c > shadow_cfg.rise_zero_threshold) lv = LVL_ZERO;
    end else begin
      if (c <= shadow_cfg.level_low_threshold) lv = LVL_NEG;
      else if (c < shadow_cfg.fall_zero_threshold) lv = LVL_ZERO;
    end
    last_corr = c;
    last_lvl  = lv;

    // the held level goes out now, replaced when it is a lone spike
    if (held_valid) begin
      o     = held_lvl;
      spike = 1'b0;
      if (!held_first && held_lvl != sent_lvl && held_lvl != lv && sent_lvl == lv) begin
        o     = sent_lvl;
        spike = 1'b1;
      end
      queue_level(o, held_corr, spike, 1'b0);
      sent_lvl   = o;
      held_valid = 1'b0;
    end

    if (item.block_last) begin
      queue_level(lv, c, 1'b0, 1'b1);
      held_valid = 1'b0;
    end else begin
      held_lvl   = lv;
      held_corr  = c;
      held_first = item.block_first;
      held_valid = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side: sample transactions, bursts and gaps
  // ---------------------------------------------------------------------------
  task automatic offer_sample(input pslf_in_t item, input bit typed, input pslf_out_t typed_res);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_levels(item);
    // a typed row states the sample's own result, which is the newest one queued
    if (typed && pending_levels.size() != 0) pending_levels[pending_levels.size() - 1] = typed_res;
    items_sent++;
  endtask

  // bursts of random length, gaps of very different lengths between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
        6, 7:             gap = $urandom_range(5, 40);
        8:                gap = $urandom_range(41, 200);
        default:          gap = 0;
      endcase
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
  endtask

  // sender stops and waits for every owed level
  task automatic drain_levels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DC_ENABLE: shadow_cfg.dc_enable            = data[0];
      CFG_DC_HIGH:   shadow_cfg.dc_high_limit        = data;
      CFG_DC_LOW:    shadow_cfg.dc_low_limit         = data;
      CFG_LVL_HIGH:  shadow_cfg.level_high_threshold = data;
      CFG_LVL_LOW:   shadow_cfg.level_low_threshold  = data;
      CFG_RISE_ZERO: shadow_cfg.rise_zero_threshold  = data;
      CFG_FALL_ZERO: shadow_cfg.fall_zero_threshold  = data;
      default: ;
    endcase
  endtask

  // block must be idle here: all levels in and the last sample settled
  task automatic load_config(input pslf_cfg_t c, input bit poke_unused);
    drain_levels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    // upper bits of the enable byte are junk, the block keeps bit 0 only
    write_reg(CFG_DC_ENABLE, {7'($urandom), c.dc_enable});
    write_reg(CFG_DC_HIGH,   c.dc_high_limit);
    write_reg(CFG_DC_LOW,    c.dc_low_limit);
    write_reg(CFG_LVL_HIGH,  c.level_high_threshold);
    write_reg(CFG_LVL_LOW,   c.level_low_threshold);
    write_reg(CFG_RISE_ZERO, c.rise_zero_threshold);
    write_reg(CFG_FALL_ZERO, c.fall_zero_threshold);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, 8'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic pslf_cfg_t cfg_of(input logic en, input logic [7:0] dh, input logic [7:0] dl,
                                       input logic [7:0] lh, input logic [7:0] ll,
                                       input logic [7:0] rz, input logic [7:0] fz);
    pslf_cfg_t c;
    c.dc_enable            = en;
    c.dc_high_limit        = dh;
    c.dc_low_limit         = dl;
    c.level_high_threshold = lh;
    c.level_low_threshold  = ll;
    c.rise_zero_threshold  = rz;
    c.fall_zero_threshold  = fz;
    return c;
  endfunction

  // sensible settings keep correction and all three levels reachable
  function automatic pslf_cfg_t rand_cfg(input bit sensible);
    logic [7:0] ll;
    if (!sensible) return cfg_of(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom));
    ll = 8'($urandom_range(40, 120));
    return cfg_of(1'b1, 8'($urandom_range(100, 250)), 8'($urandom_range(10, 120)),
                  8'($urandom_range(ll + 10, 230)), ll, 8'($urandom_range(30, 130)),
                  8'($urandom_range(110, 220)));
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] near(input int center);
    int v;
    v = center + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly well-formed blocks of oversampled symbols, plus loose samples and cut blocks
  task automatic run_phase(input int unsigned n_items);
    int unsigned done_items;
    int unsigned len;
    int unsigned run;
    int unsigned k;
    int unsigned pick;
    int unsigned sym;
    bit          paused;
    bit          broken;
    int          center [3];
    pslf_in_t    block_items [$];
    pslf_in_t    it;
    done_items = 0;
    paused     = 1'b0;
    while (done_items < n_items) begin
      block_items.delete();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // now and then a block longer than the window so it wraps
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(WIN_LEN + 1, 2 * WIN_LEN + 4)
                                           : $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        center[0] = $urandom_range(0, 80);
        center[1] = $urandom_range(80, 175);
        center[2] = $urandom_range(175, 255);
        k = 0;
        while (k < len) begin
          // runs of one make lone spikes
          run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
          sym = $urandom_range(0, 2);
          repeat (run) if (k < len) begin
            it.sample      = near(center[sym]);
            it.block_first = (k == 0);
            it.block_last  = (k == len - 1) && !broken;
            block_items.push_back(it);
            k++;
          end
        end
      end else if (pick < 90) begin
        it.sample      = 8'($urandom);
        it.block_first = 1'($urandom);
        it.block_last  = 1'($urandom);
        block_items.push_back(it);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          it.sample      = 8'($urandom);
          it.block_first = 1'b0;
          it.block_last  = 1'b0;
          block_items.push_back(it);
        end
      end
      foreach (block_items[i]) begin
        offer_sample(block_items[i], 1'b0, '0);
        pace_sender();
        done_items++;
      end
      // halfway through, the sender waits for every level to come back
      if (!paused && done_items >= n_items / 2) begin
        paused = 1'b1;
        drain_levels();
      end
    end
  endtask

  function automatic stim_row_t mk_row(input logic [7:0] s, input bit f, input bit l,
                                       input bit typed = 1'b0,
                                       input logic signed [1:0] lv = LVL_ZERO,
                                       input logic [7:0] corr = '0);
    stim_row_t r;
    r.item.sample               = s;
    r.item.block_first          = f;
    r.item.block_last           = l;
    r.typed                     = typed;
    r.result.level              = lv;
    r.result.corrected_sample   = corr;
    r.result.spike_removed      = 1'b0;
    r.result.result_last        = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed_rows [$];

    directed_rows = '{
      // samples before any block start carry on from the reset state
      mk_row(8'd100, 1'b0, 1'b0),
      mk_row(8'd120, 1'b0, 1'b0),
      // one-sample block while a result is pending: flush, then its own result
      mk_row(8'd0,   1'b1, 1'b1, 1'b1, LVL_NEG, 8'd0),
      mk_row(8'd255, 1'b1, 1'b1, 1'b1, LVL_POS, 8'd255),
      // wide swing triggers dc correction, lone samples between equal neighbours
      mk_row(8'd200, 1'b1, 1'b0),
      mk_row(8'd20,  1'b0, 1'b0),
      mk_row(8'd20,  1'b0, 1'b0),
      mk_row(8'd200, 1'b0, 1'b0),
      mk_row(8'd20,  1'b0, 1'b0),
      mk_row(8'd20,  1'b0, 1'b0),
      mk_row(8'd60,  1'b0, 1'b0),
      // shifted value would reach 255 so the sample passes unchanged
      mk_row(8'd255, 1'b0, 1'b1),
      // block cut off by a new start
      mk_row(8'd150, 1'b1, 1'b0),
      mk_row(8'd150, 1'b0, 1'b0),
      mk_row(8'd10,  1'b1, 1'b1, 1'b1, LVL_NEG, 8'd10),
      // flat block, level held between the thresholds
      mk_row(8'd128, 1'b1, 1'b0),
      mk_row(8'd128, 1'b0, 1'b0),
      mk_row(8'd128, 1'b0, 1'b1),
      // loose samples after a finished block, then a last without a start
      mk_row(8'd255, 1'b0, 1'b0),
      mk_row(8'd0,   1'b0, 1'b1),
      mk_row(8'd0,   1'b1, 1'b1, 1'b1, LVL_NEG, 8'd0)
    };

    // reset once, released at a falling edge
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part runs on the reset register values
    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      pace_sender();
    end

    // correction off, thresholds at reset
    load_config(cfg_of(1'b0, RST_DC_HIGH, RST_DC_LOW, RST_LVL_HIGH, RST_LVL_LOW,
                       RST_RISE_ZERO, RST_FALL_ZERO), 1'b0);
    run_phase(200);
    // everything at its lower end
    load_config(cfg_of(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    run_phase(150);
    // everything at its upper end
    load_config(cfg_of(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
    run_phase(150);
    // limits wide open so correction nearly always applies
    load_config(cfg_of(1'b1, 8'd0, 8'd255, 8'd150, 8'd90, 8'd70, 8'd170), 1'b0);
    run_phase(200);
    // back to reset values, plus a write to the undecoded index
    load_config(cfg_of(RST_DC_ENABLE, RST_DC_HIGH, RST_DC_LOW, RST_LVL_HIGH, RST_LVL_LOW,
                       RST_RISE_ZERO, RST_FALL_ZERO), 1'b1);
    run_phase(350);
    load_config(rand_cfg(1'b1), 1'b0);
    run_phase(200);
    load_config(rand_cfg(1'b0), 1'b1);
    run_phase(200);
    load_config(rand_cfg(1'b1), 1'b0);
    run_phase(200);

    // end of stimulus: collect the rest, then let the block go quiet
    drain_levels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d samples under %0d register settings, %0d levels checked",
             items_sent, settings_loaded + 1, results_checked);
    $display("runs included extremes, long output stall and a mid-phase drain");
    if (fail_count == 0) begin
      $display("PASS pam3_sample_level_frontend");
    end else begin
      $display("FAIL pam3_sample_level_frontend");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: changing stall patterns, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    int unsigned hold;
    int unsigned tick;
    bit          held_off;
    mode     = RX_OPEN;
    left     = 0;
    hold     = 0;
    tick     = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      // long hold-off while the sender keeps offering, fills the block up
      if (!held_off && results_checked >= HOLD_TRIGGER) begin
        held_off = 1'b1;
        hold     = LONG_HOLD;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 400);
        end
        left--;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom);
          RX_COMB:   out_ready_i <= (tick % 5) != 0;
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : level_check
    pslf_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (pending_levels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected level transaction, expected none actual %0d/%0d/%0d/%0d",
                 $time, int'(out_data_o.level), out_data_o.corrected_sample,
                 out_data_o.spike_removed, out_data_o.result_last);
      end else begin
        want = pending_levels.pop_front();
        flag_field("level", int'(want.level), int'(out_data_o.level));
        flag_field("corrected_sample", want.corrected_sample, out_data_o.corrected_sample);
        flag_field("spike_removed", want.spike_removed, out_data_o.spike_removed);
        flag_field("result_last", want.result_last, out_data_o.result_last);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d levels still owed", cycle_count,
             pending_levels.size());
    $display("FAIL pam3_sample_level_frontend");
    $finish;
  end

endmodule
